>>> hw/rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list engine: command and status
// codes, request and response words, and the per-cell control word.
// ----------------------------------------------------------------------------
package plist_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int FPOS_W  = 4;
   localparam int COUNT_W = 5;
   localparam int CAP_W   = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SORT   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd6;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } plist_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [VALUE_W-1:0] read_value;
      logic [FPOS_W-1:0]         found_position;
      logic [COUNT_W-1:0]        entry_count;
      logic                      is_full;
      logic                      is_empty;
   } plist_rsp_type;

   // Next-value select for one cell; at most one bit is set.
   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
   } plist_cell_ctl_type;

endpackage

>>> hw/rtl/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot: holds a word, loads a new word or takes a neighbor's word,
// and reports equality with the search key and order against its right
// neighbor.
// ----------------------------------------------------------------------------
module plist_cell
   import plist_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  plist_cell_ctl_type    ctl,
   input  logic [DATA_WIDTH-1:0] new_word,
   input  logic [DATA_WIDTH-1:0] left_word,
   input  logic [DATA_WIDTH-1:0] right_word,
   input  logic [DATA_WIDTH-1:0] key,
   output logic [DATA_WIDTH-1:0] word,
   output logic                  match,
   output logic                  gt_right
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   always_comb begin
      if (ctl.load) begin
         word_in = new_word;
      end else if (ctl.take_left) begin
         word_in = left_word;
      end else if (ctl.take_right) begin
         word_in = right_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word     = word_ff;
   assign match    = (word_ff == key);
   assign gt_right = ($signed(word_ff) > $signed(right_word));

endmodule

>>> hw/rtl/plist_ctrl.sv
// ----------------------------------------------------------------------------
// plist_ctrl
// Command sequencer for the cell row: keeps count and capacity, decodes
// commands into per-cell selects, runs the odd-even exchange sort and the
// first-match search, and registers the response word.
// ----------------------------------------------------------------------------
module plist_ctrl
   import plist_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  plist_req_type                        req_data,
   output logic                                 rsp_valid,
   output plist_rsp_type                        rsp_data,
   input  logic                                 csr_valid,
   input  logic [CAP_W-1:0]                     csr_data,
   input  logic [DEPTH-1:0][DATA_WIDTH-1:0]     words,
   input  logic [DEPTH-1:0]                     match_vec,
   input  logic [DEPTH-1:0]                     gt_vec,
   output plist_cell_ctl_type [DEPTH-1:0]       cell_ctl,
   output logic [DATA_WIDTH-1:0]                key_word
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_SORT
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CW-1:0]     phase_ff, phase_in;
   logic [DEPTH-1:0]  match_ff, match_in;
   plist_rsp_type     rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept;
   logic [CMPW-1:0]   pos_w;
   logic [CMPW-1:0]   cnt_w;
   logic              full_now;
   logic              ins_ok;
   logic              rem_ok;
   logic              app_ok;
   logic [DEPTH-1:0]  valid_mask;
   logic [DEPTH-1:0]  first_hit;
   logic [CMPW-1:0]   hit_idx;
   logic [DEPTH-1:0]  gt_from_left;
   logic [CMPW-1:0]   cnt_next_w;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign key_word = DATA_WIDTH'(req_data.value);
   assign pos_w    = CMPW'(req_data.position);
   assign cnt_w    = CMPW'(count_ff);
   assign full_now = (cnt_w >= CMPW'(cap_ff)) || (count_ff == CW'(DEPTH));
   assign app_ok   = !full_now;
   assign ins_ok   = !full_now && (pos_w <= cnt_w);
   assign rem_ok   = (pos_w < cnt_w);

   assign gt_from_left = {gt_vec[DEPTH-2:0], 1'b0};

   // First set bit of the stored match vector, then its index.
   assign first_hit = match_ff & (~match_ff + 1'b1);

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | CMPW'(i);
         end
      end
   end

   // Per-cell selects.
   always_comb begin
      logic [CMPW-1:0] idx_w;
      for (int i = 0; i < DEPTH; i++) begin
         idx_w = CMPW'(i);
         cell_ctl[i] = '0;
         valid_mask[i] = (idx_w < cnt_w);
         if (accept) begin
            case (req_data.command)
               CMD_APPEND: begin
                  cell_ctl[i].load = app_ok && (idx_w == cnt_w);
               end
               CMD_INSERT: begin
                  cell_ctl[i].load      = ins_ok && (idx_w == pos_w);
                  cell_ctl[i].take_left = ins_ok && (idx_w > pos_w);
               end
               CMD_REMOVE: begin
                  cell_ctl[i].take_right = rem_ok && (idx_w >= pos_w);
               end
               default: begin
               end
            endcase
         end else if (state_ff == S_SORT) begin
            // Lower cell of an active pair takes the smaller word, upper the larger.
            if ((idx_w[0] == phase_ff[0]) && ((idx_w + 1'b1) < cnt_w)) begin
               cell_ctl[i].take_right = gt_vec[i];
            end else if ((idx_w[0] != phase_ff[0]) && (idx_w != '0) && (idx_w < cnt_w)) begin
               cell_ctl[i].take_left = gt_from_left[i];
            end
         end
      end
   end

   always_comb begin
      logic [STAT_W-1:0]         stat;
      logic signed [VALUE_W-1:0] rd;
      logic [CMPW-1:0]           fp;
      state_in     = state_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      match_in     = match_ff;
      cap_in       = csr_valid ? csr_data : cap_ff;
      rsp_valid_in = 1'b0;
      stat         = STAT_OK;
      rd           = '0;
      fp           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_data.command)
                  CMD_APPEND: begin
                     if (app_ok) count_in = count_ff + 1'b1;
                     else stat = STAT_FULL;
                  end
                  CMD_INSERT: begin
                     if (full_now) stat = STAT_FULL;
                     else if (!ins_ok) stat = STAT_BADPOS;
                     else count_in = count_ff + 1'b1;
                  end
                  CMD_REMOVE: begin
                     if (rem_ok) count_in = count_ff - 1'b1;
                     else stat = STAT_BADPOS;
                  end
                  CMD_READ: begin
                     if (rem_ok) rd = VALUE_W'($signed(words[pos_w[IW-1:0]]));
                     else stat = STAT_BADPOS;
                  end
                  CMD_FIND: begin
                     rsp_valid_in = 1'b0;
                     match_in     = match_vec & valid_mask;
                     state_in     = S_FIND;
                  end
                  CMD_SORT: begin
                     if (cnt_w > CMPW'(1)) begin
                        rsp_valid_in = 1'b0;
                        phase_in     = '0;
                        state_in     = S_SORT;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIND: begin
            rsp_valid_in = 1'b1;
            if (match_ff == '0) stat = STAT_NOTFOUND;
            else fp = hit_idx;
            state_in = S_IDLE;
         end
         S_SORT: begin
            phase_in = phase_ff + 1'b1;
            if (phase_ff == (count_ff - 1'b1)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      cnt_next_w            = CMPW'(count_in);
      rsp_in.status         = stat;
      rsp_in.read_value     = rd;
      rsp_in.found_position = fp[FPOS_W-1:0];
      rsp_in.entry_count    = cnt_next_w[COUNT_W-1:0];
      rsp_in.is_full        = (cnt_next_w >= CMPW'(cap_ff)) || (count_in == CW'(DEPTH));
      rsp_in.is_empty       = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      match_ff <= match_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/positional_list_engine_core.sv
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list of signed words held in a row of cells, with append,
// insert, remove, read, find, sort and clear commands.
// ----------------------------------------------------------------------------
// Each accepted command yields one response word, strobed on rsp_valid for a
// single cycle; the receiver cannot stall it and must take it then. Append,
// insert, remove, read, clear and unused codes respond in the cycle after
// start and busy stays low, so a new command may follow at once. Find
// compares all cells when accepted, holds busy while it picks the first hit,
// and then responds. Sort holds busy through its odd-even neighbor exchange
// phases across the cell row, and responds the cycle after the last phase;
// lists of fewer than two entries respond like append, without busy. The
// capacity register is written through csr_valid, which is always ready.
// ----------------------------------------------------------------------------
module positional_list_engine_core
   import plist_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  plist_req_type     req_data,
   output logic              rsp_valid,
   output plist_rsp_type     rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   logic [DEPTH-1:0][DATA_WIDTH-1:0] words;
   logic [DEPTH-1:0]                 match_vec;
   logic [DEPTH-1:0]                 gt_vec;
   plist_cell_ctl_type [DEPTH-1:0]   cell_ctl;
   logic [DATA_WIDTH-1:0]            key_word;

   assign csr_ready = 1'b1;

   plist_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .words     (words),
      .match_vec (match_vec),
      .gt_vec    (gt_vec),
      .cell_ctl  (cell_ctl),
      .key_word  (key_word)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      // End cells see themselves past the row edge.
      if (g == 0) begin : g_first
         assign left_w = words[g];
      end else begin : g_inner_l
         assign left_w = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = words[g];
      end else begin : g_inner_r
         assign right_w = words[g+1];
      end

      plist_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[g]),
         .new_word   (key_word),
         .left_word  (left_w),
         .right_word (right_w),
         .key        (key_word),
         .word       (words[g]),
         .match      (match_vec[g]),
         .gt_right   (gt_vec[g])
      );
   end

endmodule

>>> test/positional_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_checker
// Watches the command, response and capacity channels of the list engine,
// keeps its own copy of the list, predicts every response word and compares
// it field by field with what the engine returns.
// ----------------------------------------------------------------------------
module positional_list_checker
   import plist_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  plist_req_type     req_data,
   input  logic              rsp_valid,
   input  plist_rsp_type     rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data,
   output int                error_count,
   output int                responses_checked,
   output int                pending
);

   localparam int DEPTH = DEPTH_DEFAULT;

   logic signed [VALUE_W-1:0] cells [DEPTH];
   int                        list_count;
   int                        capacity;
   plist_rsp_type             awaited_responses [$];
   plist_rsp_type             expected;
   bit                        bad;

   // Apply one command to the shadow list and return the response word it earns.
   function automatic plist_rsp_type apply_command(plist_req_type item);
      plist_rsp_type             rsp;
      int                        cap;
      int                        pos;
      int                        i;
      int                        j;
      bit                        hit;
      logic signed [VALUE_W-1:0] key;
      rsp = '0;
      rsp.status = STAT_OK;
      cap = (capacity > DEPTH) ? DEPTH : capacity;
      pos = int'(item.position);
      hit = 1'b0;
      case (item.command)
         CMD_APPEND: begin
            if (list_count >= cap) rsp.status = STAT_FULL;
            else begin
               cells[list_count] = item.value;
               list_count++;
            end
         end
         CMD_INSERT: begin
            if (list_count >= cap) rsp.status = STAT_FULL;
            else if (pos > list_count) rsp.status = STAT_BADPOS;
            else begin
               for (i = list_count; i > pos; i--) cells[i] = cells[i-1];
               cells[pos] = item.value;
               list_count++;
            end
         end
         CMD_REMOVE: begin
            if (pos >= list_count) rsp.status = STAT_BADPOS;
            else begin
               for (i = pos; i + 1 < list_count; i++) cells[i] = cells[i+1];
               list_count--;
            end
         end
         CMD_READ: begin
            if (pos >= list_count) rsp.status = STAT_BADPOS;
            else rsp.read_value = cells[pos];
         end
         CMD_FIND: begin
            rsp.status = STAT_NOTFOUND;
            for (i = 0; i < list_count && !hit; i++) begin
               if (cells[i] == item.value) begin
                  hit = 1'b1;
                  rsp.status = STAT_OK;
                  rsp.found_position = FPOS_W'(i);
               end
            end
         end
         CMD_SORT: begin
            for (i = 1; i < list_count; i++) begin
               key = cells[i];
               j = i;
               while (j > 0 && cells[j-1] > key) begin
                  cells[j] = cells[j-1];
                  j--;
               end
               cells[j] = key;
            end
         end
         CMD_CLEAR: list_count = 0;
         default: ;
      endcase
      rsp.entry_count = COUNT_W'(list_count);
      rsp.is_full     = (list_count >= cap);
      rsp.is_empty    = (list_count == 0);
      return rsp;
   endfunction

   function automatic bit field_differs(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         awaited_responses.delete();
         list_count = 0;
         capacity = int'(CAP_RESET);
         error_count = 0;
         responses_checked = 0;
      end else begin
         if (csr_valid && csr_ready) capacity = int'(csr_data);
         if (start && !busy) awaited_responses.push_back(apply_command(req_data));
         if (rsp_valid) begin
            responses_checked++;
            if (awaited_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %0h", $time, rsp_data);
               error_count++;
            end else begin
               expected = awaited_responses.pop_front();
               bad = 1'b0;
               bad |= field_differs("status", 32'(expected.status), 32'(rsp_data.status));
               bad |= field_differs("read_value", expected.read_value, rsp_data.read_value);
               bad |= field_differs("found_position", 32'(expected.found_position),
                                    32'(rsp_data.found_position));
               bad |= field_differs("entry_count", 32'(expected.entry_count),
                                    32'(rsp_data.entry_count));
               bad |= field_differs("is_full", 32'(expected.is_full), 32'(rsp_data.is_full));
               bad |= field_differs("is_empty", 32'(expected.is_empty), 32'(rsp_data.is_empty));
               if (bad) error_count++;
            end
         end
      end
      pending <= awaited_responses.size();
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional list engine with a directed opening and then phases
// of weighted random commands under several capacity settings, with random
// gaps on the command side; the checker scores every response word.
// ----------------------------------------------------------------------------
module testbench;
   import plist_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED   = 3'd7;
   localparam int               STALL_LIMIT  = 2000;
   localparam int               PHASES       = 10;
   localparam int               PHASE_ITEMS  = 62;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   plist_req_type     req_data;
   logic              rsp_valid;
   plist_rsp_type     rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data;

   int error_count;
   int responses_checked;
   int pending;
   int commands_sent;
   int capacity_writes;
   int stall_cycles;
   bit gaps_on;

   logic signed [VALUE_W-1:0] value_pool [8];
   logic [CAP_W-1:0]          phase_caps [PHASES] = '{5'd31, 5'd4, 5'd16, 5'd0, 5'd1,
                                                      5'd9, 5'd16, 5'd2, 5'd31, 5'd12};

   positional_list_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   positional_list_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .responses_checked (responses_checked),
      .pending           (pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic plist_req_type make_item(logic [CMD_W-1:0] cmd, int pos,
                                               logic [VALUE_W-1:0] val);
      plist_req_type item;
      item.command  = cmd;
      item.position = POS_W'(pos);
      item.value    = val;
      return item;
   endfunction

   function automatic plist_req_type random_command();
      plist_req_type item;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      item.command = CMD_APPEND;
      else if (pick < 46) item.command = CMD_INSERT;
      else if (pick < 63) item.command = CMD_REMOVE;
      else if (pick < 76) item.command = CMD_READ;
      else if (pick < 89) item.command = CMD_FIND;
      else if (pick < 94) item.command = CMD_SORT;
      else if (pick < 96) item.command = CMD_CLEAR;
      else if (pick < 98) item.command = CMD_UNUSED;
      else                item.command = CMD_W'($urandom);
      // keep most positions near the live range
      if ($urandom_range(0, 99) < 85) item.position = POS_W'($urandom_range(0, 16));
      else                            item.position = POS_W'($urandom);
      if ($urandom_range(0, 99) < 60) item.value = value_pool[$urandom_range(0, 7)];
      else                            item.value = $urandom;
      return item;
   endfunction

   task automatic send_command(input plist_req_type item);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      commands_sent++;
   endtask

   // Write only with the engine idle and no response outstanding.
   task automatic write_capacity(input logic [CAP_W-1:0] cap_value);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap_value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      capacity_writes++;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      commands_sent   = 0;
      capacity_writes = 0;
      gaps_on         = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases, then build, search, sort and drain
      send_command(make_item(CMD_READ,   0, 32'h0));
      send_command(make_item(CMD_REMOVE, 0, 32'h0));
      send_command(make_item(CMD_FIND,   0, 32'h0));
      send_command(make_item(CMD_SORT,   0, 32'h0));
      send_command(make_item(CMD_INSERT, 1, 32'h1));
      send_command(make_item(CMD_INSERT, 0, 32'h7fffffff));
      send_command(make_item(CMD_APPEND, 0, 32'h80000000));
      send_command(make_item(CMD_APPEND, 31, 32'hffffffff));
      send_command(make_item(CMD_INSERT, 3, 32'h0));
      send_command(make_item(CMD_INSERT, 1, 32'h5));
      send_command(make_item(CMD_FIND,   0, 32'hffffffff));
      send_command(make_item(CMD_FIND,   0, 32'h12345));
      send_command(make_item(CMD_READ,   31, 32'h0));
      send_command(make_item(CMD_READ,   16, 32'h0));
      send_command(make_item(CMD_SORT,   0, 32'h0));
      send_command(make_item(CMD_READ,   0, 32'h0));
      send_command(make_item(CMD_READ,   4, 32'h0));
      send_command(make_item(CMD_REMOVE, 4, 32'h0));
      send_command(make_item(CMD_REMOVE, 0, 32'h0));
      send_command(make_item(CMD_UNUSED, 31, 32'hdeadbeef));
      send_command(make_item(CMD_CLEAR,  0, 32'h0));
      send_command(make_item(CMD_APPEND, 0, 32'h55555555));
      send_command(make_item(CMD_INSERT, 0, 32'haaaaaaaa));
      send_command(make_item(CMD_SORT,   0, 32'h0));
      // capacity dropped below the count: full wins over a bad position
      write_capacity(5'd1);
      send_command(make_item(CMD_APPEND, 0, 32'h1));
      send_command(make_item(CMD_INSERT, 9, 32'h2));
      write_capacity(5'd0);
      send_command(make_item(CMD_CLEAR,  0, 32'h0));
      send_command(make_item(CMD_APPEND, 0, 32'h3));

      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         value_pool[0] = 32'h80000000;
         value_pool[1] = 32'h7fffffff;
         value_pool[2] = 32'h0;
         value_pool[3] = 32'hffffffff;
         for (int k = 4; k < 8; k++) value_pool[k] = $urandom;
         // idle-free stretches, and none at all in the closing phase
         gaps_on = (phase % 3 != 2) && (phase != PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) send_command(random_command());
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("ran %0d commands across %0d capacity settings, %0d responses scored",
               commands_sent, capacity_writes, responses_checked);
      if (pending != 0) $display("%0t: %0d responses never arrived", $time, pending);
      if (error_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
